>>> design/rqf_pkg.sv
// rqf_pkg: shared types and constants for the read quality filter.
// No dependencies; imported by every design file.
package rqf_pkg;

	localparam int unsigned REG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 17;
	localparam int unsigned QSUM_W     = 26;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_FILTER_ENABLES    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_QUALIFIED_QUAL    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_UNQUAL_PCT_LIMIT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_AVG_QUAL_REQUIRED = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_N_BASE_LIMIT      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_REQUIRED_LENGTH   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MAXIMUM_LENGTH    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_COMPLEXITY_THR    = 3'd7;

	// verdict codes
	localparam logic [2:0] VERDICT_PASS           = 3'd0;
	localparam logic [2:0] VERDICT_TOO_SHORT      = 3'd1;
	localparam logic [2:0] VERDICT_QUALITY        = 3'd2;
	localparam logic [2:0] VERDICT_TOO_MANY_N     = 3'd3;
	localparam logic [2:0] VERDICT_TOO_LONG       = 3'd4;
	localparam logic [2:0] VERDICT_LOW_COMPLEXITY = 3'd5;

	// filter enable bits
	localparam int unsigned EN_QUALITY    = 0;
	localparam int unsigned EN_LENGTH     = 1;
	localparam int unsigned EN_COMPLEXITY = 2;

	localparam logic [7:0] PHRED_OFFSET = 8'd33;
	localparam logic [7:0] BASE_N       = 8'h4E;
	localparam logic [6:0] PERCENT_SCALE = 7'd100;

	localparam logic signed [QSUM_W-1:0] QSUM_MAX = {1'b0, {(QSUM_W-1){1'b1}}};
	localparam logic signed [QSUM_W-1:0] QSUM_MIN = {1'b1, {(QSUM_W-1){1'b0}}};

	typedef struct packed {
		logic [2:0]  enables;
		logic [7:0]  qual_char;
		logic [6:0]  pct_limit;
		logic [6:0]  avg_req;
		logic [15:0] n_limit;
		logic [15:0] min_len;
		logic [15:0] max_len;
		logic [16:0] cplx_thr;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		enables:   3'd3,
		qual_char: 8'd48,
		pct_limit: 7'd40,
		avg_req:   7'd0,
		n_limit:   16'd5,
		min_len:   16'd15,
		max_len:   16'd0,
		cplx_thr:  17'd19661
	};

endpackage

>>> design/rqf_ifs.sv
// Channel interfaces of the read quality filter: base items, verdicts, register writes.
// Depends on rqf_pkg.
interface rqf_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] base_char;
	logic [7:0] quality_char;
	logic       last_base;
	logic       empty_read;

	modport source (output valid, base_char, quality_char, last_base, empty_read, input ready);
	modport sink   (input valid, base_char, quality_char, last_base, empty_read, output ready);
endinterface

interface rqf_verdict_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;

	modport source (output valid, verdict, input ready);
	modport sink   (input valid, verdict, output ready);
endinterface

interface rqf_cfg_if import rqf_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> design/rqf_regs.sv
// rqf_regs: configuration register file, written through the cfg channel.
// Depends on rqf_pkg and rqf_cfg_if.
module rqf_regs import rqf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rqf_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FILTER_ENABLES:    regs_q.enables   <= cfg.data[2:0];
				REG_QUALIFIED_QUAL:    regs_q.qual_char <= cfg.data[7:0];
				REG_UNQUAL_PCT_LIMIT:  regs_q.pct_limit <= cfg.data[6:0];
				REG_AVG_QUAL_REQUIRED: regs_q.avg_req   <= cfg.data[6:0];
				REG_N_BASE_LIMIT:      regs_q.n_limit   <= cfg.data[15:0];
				REG_REQUIRED_LENGTH:   regs_q.min_len   <= cfg.data[15:0];
				REG_MAXIMUM_LENGTH:    regs_q.max_len   <= cfg.data[15:0];
				REG_COMPLEXITY_THR:    regs_q.cplx_thr  <= cfg.data[16:0];
			endcase
		end
	end

endmodule

>>> design/rqf_accum.sv
// rqf_accum: per-read counters updated on every accepted base until the length count saturates;
// snapshot register holding the final counts of a finished read. Depends on rqf_pkg and rqf_item_if.
module rqf_accum import rqf_pkg::*; #(
	parameter  int unsigned MAX_READ_LEN = 65535,
	localparam int unsigned CNT_W        = $clog2(MAX_READ_LEN + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	rqf_item_if.sink                 items,
	input  cfg_t                     regs,
	output logic                     snap_valid,
	input  logic                     snap_ready,
	output logic [CNT_W-1:0]         snap_len,
	output logic [CNT_W-1:0]         snap_low,
	output logic [CNT_W-1:0]         snap_n,
	output logic [CNT_W-1:0]         snap_chg,
	output logic signed [QSUM_W-1:0] snap_qsum
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_READ_LEN);

	logic [CNT_W-1:0]         len_q, low_q, n_q, chg_q;
	logic signed [QSUM_W-1:0] qsum_q;
	logic [7:0]               prev_q;
	logic                     snap_valid_q;
	logic [CNT_W-1:0]         len_s1, low_s1, n_s1, chg_s1;
	logic signed [QSUM_W-1:0] qsum_s1;

	logic [CNT_W-1:0]         len_nxt, low_nxt, n_nxt, chg_nxt;
	logic signed [QSUM_W-1:0] qsum_nxt;
	logic [7:0]               prev_nxt;
	logic signed [9:0]        qual_delta;
	logic signed [QSUM_W:0]   qsum_wide;
	logic                     take, finish;

	assign items.ready = !snap_valid_q || snap_ready;
	assign take        = items.valid && items.ready;
	assign finish      = take && (items.empty_read || items.last_base);

	assign qual_delta = $signed({2'b00, items.quality_char}) - $signed({2'b00, PHRED_OFFSET});
	assign qsum_wide  = (QSUM_W+1)'(qsum_q) + (QSUM_W+1)'(qual_delta);

	always_comb begin
		len_nxt  = len_q;
		low_nxt  = low_q;
		n_nxt    = n_q;
		chg_nxt  = chg_q;
		qsum_nxt = qsum_q;
		prev_nxt = prev_q;
		if (len_q != MAX_CNT) begin
			len_nxt  = len_q + CNT_W'(1);
			prev_nxt = items.base_char;
			if (len_q != '0 && items.base_char != prev_q)
				chg_nxt = chg_q + CNT_W'(1);
			if (items.quality_char < regs.qual_char)
				low_nxt = low_q + CNT_W'(1);
			if (items.base_char == BASE_N)
				n_nxt = n_q + CNT_W'(1);
			if (qsum_wide[QSUM_W] != qsum_wide[QSUM_W-1])
				qsum_nxt = qsum_wide[QSUM_W] ? QSUM_MIN : QSUM_MAX;
			else
				qsum_nxt = qsum_wide[QSUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			low_q  <= '0;
			n_q    <= '0;
			chg_q  <= '0;
			qsum_q <= '0;
			prev_q <= '0;
		end else if (take) begin
			if (items.empty_read || items.last_base) begin
				len_q  <= '0;
				low_q  <= '0;
				n_q    <= '0;
				chg_q  <= '0;
				qsum_q <= '0;
				prev_q <= '0;
			end else begin
				len_q  <= len_nxt;
				low_q  <= low_nxt;
				n_q    <= n_nxt;
				chg_q  <= chg_nxt;
				qsum_q <= qsum_nxt;
				prev_q <= prev_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			snap_valid_q <= 1'b0;
		else if (finish)
			snap_valid_q <= 1'b1;
		else if (snap_ready)
			snap_valid_q <= 1'b0;
	end

	// empty read: zero length, decides as too short
	always_ff @(posedge clk) begin
		if (finish) begin
			if (items.empty_read) begin
				len_s1  <= '0;
				low_s1  <= '0;
				n_s1    <= '0;
				chg_s1  <= '0;
				qsum_s1 <= '0;
			end else begin
				len_s1  <= len_nxt;
				low_s1  <= low_nxt;
				n_s1    <= n_nxt;
				chg_s1  <= chg_nxt;
				qsum_s1 <= qsum_nxt;
			end
		end
	end

	assign snap_valid = snap_valid_q;
	assign snap_len   = len_s1;
	assign snap_low   = low_s1;
	assign snap_n     = n_s1;
	assign snap_chg   = chg_s1;
	assign snap_qsum  = qsum_s1;

endmodule

>>> design/rqf_judge.sv
// rqf_judge: product stage and compare stage turning final read counts into a verdict;
// the compare stage is the output register. Depends on rqf_pkg and rqf_verdict_if.
module rqf_judge import rqf_pkg::*; #(
	parameter  int unsigned CNT_W = 16,
	localparam int unsigned PW    = CNT_W + 7,
	localparam int unsigned TW    = CNT_W + 17,
	localparam int unsigned AW    = (PW > QSUM_W) ? PW : QSUM_W,
	localparam int unsigned LW    = (CNT_W > 16) ? CNT_W : 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     regs,
	input  logic                     snap_valid,
	output logic                     snap_ready,
	input  logic [CNT_W-1:0]         snap_len,
	input  logic [CNT_W-1:0]         snap_low,
	input  logic [CNT_W-1:0]         snap_n,
	input  logic [CNT_W-1:0]         snap_chg,
	input  logic signed [QSUM_W-1:0] snap_qsum,
	rqf_verdict_if.source            results
);

	logic                     valid_s2;
	logic [PW-1:0]            low_pct_s2, lim_len_s2, req_len_s2;
	logic [TW-1:0]            thr_len_s2;
	logic [CNT_W-1:0]         len_s2, n_s2, chg_s2;
	logic signed [QSUM_W-1:0] qsum_s2;
	logic                     valid_q;
	logic [2:0]               verdict_q;

	logic       adv_s2;
	logic       fail_pct, fail_avg, fail_n, fail_short, fail_long, fail_cplx;
	logic [2:0] verdict_d;

	assign adv_s2     = valid_s2 && (!valid_q || results.ready);
	assign snap_ready = !valid_s2 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (snap_ready)
			valid_s2 <= snap_valid;
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			low_pct_s2 <= PW'(snap_low) * PW'(PERCENT_SCALE);
			lim_len_s2 <= PW'(regs.pct_limit) * PW'(snap_len);
			req_len_s2 <= PW'(regs.avg_req) * PW'(snap_len);
			thr_len_s2 <= TW'(regs.cplx_thr) * TW'(snap_len - CNT_W'(1));
			len_s2     <= snap_len;
			n_s2       <= snap_n;
			chg_s2     <= snap_chg;
			qsum_s2    <= snap_qsum;
		end
	end

	always_comb begin
		fail_pct   = low_pct_s2 > lim_len_s2;
		fail_avg   = (regs.avg_req != '0) &&
			(qsum_s2[QSUM_W-1] || ($unsigned(AW'(qsum_s2)) < AW'(req_len_s2)));
		fail_n     = LW'(n_s2) > LW'(regs.n_limit);
		fail_short = LW'(len_s2) < LW'(regs.min_len);
		fail_long  = (regs.max_len != '0) && (LW'(len_s2) > LW'(regs.max_len));
		fail_cplx  = (len_s2 <= CNT_W'(1)) || (TW'({chg_s2, 16'h0000}) < thr_len_s2);

		verdict_d = VERDICT_PASS;
		if (len_s2 == '0)
			verdict_d = VERDICT_TOO_SHORT;
		else if (regs.enables[EN_QUALITY] && (fail_pct || fail_avg))
			verdict_d = VERDICT_QUALITY;
		else if (regs.enables[EN_QUALITY] && fail_n)
			verdict_d = VERDICT_TOO_MANY_N;
		else if (regs.enables[EN_LENGTH] && fail_short)
			verdict_d = VERDICT_TOO_SHORT;
		else if (regs.enables[EN_LENGTH] && fail_long)
			verdict_d = VERDICT_TOO_LONG;
		else if (regs.enables[EN_COMPLEXITY] && fail_cplx)
			verdict_d = VERDICT_LOW_COMPLEXITY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv_s2)
			valid_q <= 1'b1;
		else if (results.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s2)
			verdict_q <= verdict_d;
	end

	assign results.valid   = valid_q;
	assign results.verdict = verdict_q;

endmodule

>>> design/read_quality_filter_core.sv
// read_quality_filter_core: top level of the streaming read quality filter.
// Depends on rqf_pkg, rqf_ifs, rqf_regs, rqf_accum and rqf_judge.
//
//  channel  dir  payload                                          transfer when
//  items    in   base_char, quality_char, last_base, empty_read   items.valid && items.ready
//  results  out  verdict                                          results.valid && results.ready
//  cfg      in   index, data                                      cfg.valid && cfg.ready
//
// One base per cycle while items.ready is high; counters update in the cycle a base transfers.
// After the last base (or empty read) transfers, its verdict passes the snapshot register,
// the product register and the compare/output register before it is offered on results.
// items.ready drops only when all three verdict stages hold reads; cfg.ready is always high.
// Reset (arst_n low) clears counters, stage valids and restores register defaults.
module read_quality_filter_core import rqf_pkg::*; #(
	parameter int unsigned MAX_READ_LEN = 65535
) (
	input  logic          clk,
	input  logic          arst_n,
	rqf_item_if.sink      items,
	rqf_verdict_if.source results,
	rqf_cfg_if.sink       cfg
);

	localparam int unsigned CNT_W = $clog2(MAX_READ_LEN + 1);

	cfg_t                     regs;
	logic                     snap_valid, snap_ready;
	logic [CNT_W-1:0]         snap_len, snap_low, snap_n, snap_chg;
	logic signed [QSUM_W-1:0] snap_qsum;

	rqf_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	rqf_accum #(
		.MAX_READ_LEN (MAX_READ_LEN)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.regs       (regs),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap_len   (snap_len),
		.snap_low   (snap_low),
		.snap_n     (snap_n),
		.snap_chg   (snap_chg),
		.snap_qsum  (snap_qsum)
	);

	rqf_judge #(
		.CNT_W (CNT_W)
	) u_judge (
		.clk        (clk),
		.arst_n     (arst_n),
		.regs       (regs),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap_len   (snap_len),
		.snap_low   (snap_low),
		.snap_n     (snap_n),
		.snap_chg   (snap_chg),
		.snap_qsum  (snap_qsum),
		.results    (results)
	);

`ifndef SYNTHESIS
	a_empty_snap: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready && items.empty_read |=> snap_valid && snap_len == '0)
		else $error("empty read did not produce a zero-length snapshot");

	a_low_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid |-> snap_low <= snap_len && snap_n <= snap_len)
		else $error("snapshot counts exceed read length");

	a_chg_lt_len: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid && snap_len != '0 |-> snap_chg < snap_len)
		else $error("change count not below read length");

	a_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid |-> snap_len <= CNT_W'(MAX_READ_LEN))
		else $error("read length beyond saturation limit");
`endif

endmodule
